/* rtl/core/dynamic_partition_allocator_unit_defines.svh */
// Assertion macros for the dynamic partition allocator.
// Used by dynamic_partition_allocator_unit; needs clk and rst_n in scope.
`ifndef DYNAMIC_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define DYNAMIC_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dpa_pkg.sv */
// Package for the dynamic partition allocator: table entry and result types,
// status, mode and register codes. No dependencies.
package dpa_pkg;

  localparam int MAX_PARTS_DEF = 32;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_EVICT   = 2'd1;
  localparam logic [1:0] MODE_COMPACT = 2'd2;
  localparam logic [1:0] MODE_TOUCH   = 2'd3;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_NO_VICTIM = 3'd3;
  localparam logic [2:0] ST_MOVED     = 3'd4;
  localparam logic [2:0] ST_COMPACTED = 3'd5;
  localparam logic [2:0] ST_TOUCHED   = 3'd6;
  localparam logic [2:0] ST_TOUCH_MISS = 3'd7;

  localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;
  localparam logic [1:0] REG_MIN_SIZE   = 2'd1;
  localparam logic [1:0] REG_FIT        = 2'd2;
  localparam logic [1:0] REG_VICTIM     = 2'd3;

  localparam logic [15:0] TOTAL_SIZE_RST = 16'd4096;
  localparam logic [15:0] MIN_SIZE_RST   = 16'd16;

  typedef struct packed {
    logic [15:0] base_addr;
    logic [15:0] len;
    logic        used;
    logic [31:0] alloc_stamp;
    logic [31:0] use_stamp;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] base;
    logic [15:0] length;
    logic [15:0] new_base;
    logic [4:0]  slot;
    logic        last;
  } result_t;

  localparam entry_t RESET_ENTRY = '{base_addr: 16'd0, len: TOTAL_SIZE_RST, used: 1'b0,
                                     alloc_stamp: 32'd0, use_stamp: 32'd0};

endpackage

/* rtl/core/dynamic_partition_allocator_unit.sv */
// Dynamic partition allocator. One request is handled at a time; in_stall is high
// from the transfer of a request until its last result is loaded. The partition
// table sits in a synchronous RAM with one read and one write port, so a request
// scans the table at one entry per cycle (a compact holds while the result side
// stalls), then a split or merge shifts the entries behind it at one per cycle;
// the last result waits while the result side stalls.
// After reset the table holds one free partition of 4096 units; no clearing pass.
// Depends on dpa_pkg and dynamic_partition_allocator_unit_defines.svh.
`include "dynamic_partition_allocator_unit_defines.svh"

module dynamic_partition_allocator_unit #(
  parameter int MAX_PARTS = dpa_pkg::MAX_PARTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_touch_base,
  input  logic [31:0] in_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_base,
  output logic [15:0] out_length,
  output logic [15:0] out_new_base,
  output logic [4:0]  out_slot,
  output logic        out_last
);

  localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_AL_DEC = 4'd2;
  localparam logic [3:0] S_SH_UP  = 4'd3;
  localparam logic [3:0] S_AL_WR  = 4'd4;
  localparam logic [3:0] S_EV_DEC = 4'd5;
  localparam logic [3:0] S_EV_L   = 4'd6;
  localparam logic [3:0] S_EV_R   = 4'd7;
  localparam logic [3:0] S_SH_DN  = 4'd8;
  localparam logic [3:0] S_CP_END = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  // Configuration registers.
  logic [15:0] total_r, min_r;
  logic        fit_r, victim_r;
  logic        cfg_we;

  // Table RAM.
  dpa_pkg::entry_t mem [MAX_PARTS];
  dpa_pkg::entry_t rd_raw_r, entry_rd, mem_wd;
  logic [AW-1:0]   mem_ra, mem_wa;
  logic            mem_we;
  logic            rd_zero_r, valid0_r;

  // Control.
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [15:0]   size_r, size_nxt, tb_r, tb_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic [CW-1:0] idx_r, idx_nxt, count_r, count_nxt, n_r, n_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   pick_base_r, pick_base_nxt, pick_len_r, pick_len_nxt;
  logic [31:0]   key_r, key_nxt;
  logic          left_free_r, left_free_nxt;
  logic [15:0]   left_base_r, left_base_nxt, left_len_r, left_len_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [16:0]   end_r, end_nxt;
  dpa_pkg::result_t res_r, res_nxt, out_r, out_nxt;
  logic          out_valid_r, load_out, out_free, accept;

  logic [15:0]   req_raised;
  logic          fits, better, right_free;
  logic [31:0]   sel_stamp;
  logic [CW-1:0] t_idx, src_idx;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (paddr[3:2])
      dpa_pkg::REG_TOTAL_SIZE: prdata = {16'd0, total_r};
      dpa_pkg::REG_MIN_SIZE:   prdata = {16'd0, min_r};
      dpa_pkg::REG_FIT:        prdata = {31'd0, fit_r};
      dpa_pkg::REG_VICTIM:     prdata = {31'd0, victim_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= dpa_pkg::TOTAL_SIZE_RST;
      min_r    <= dpa_pkg::MIN_SIZE_RST;
      fit_r    <= 1'b0;
      victim_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        dpa_pkg::REG_TOTAL_SIZE: total_r <= pwdata[15:0];
        dpa_pkg::REG_MIN_SIZE:   min_r <= pwdata[15:0];
        dpa_pkg::REG_FIT:        fit_r <= pwdata[0];
        dpa_pkg::REG_VICTIM:     victim_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_raw_r  <= mem[mem_ra];
    rd_zero_r <= (mem_ra == '0);
  end

  // Entry zero holds the reset partition until it is first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (mem_we && mem_wa == '0) begin
      valid0_r <= 1'b1;
    end
  end

  assign entry_rd = (rd_zero_r && !valid0_r) ? dpa_pkg::RESET_ENTRY : rd_raw_r;

  assign req_raised = (in_req_size < min_r) ? min_r : in_req_size;
  assign sel_stamp  = victim_r ? entry_rd.use_stamp : entry_rd.alloc_stamp;
  assign fits       = !entry_rd.used && entry_rd.len >= size_r;
  assign better     = !found_r || (fit_r && entry_rd.len < pick_len_r);
  assign right_free = (CW'(pick_r) + CW'(1) < count_r) && !entry_rd.used;
  assign t_idx      = left_free_r ? CW'(pick_r) - CW'(1) : CW'(pick_r);
  assign src_idx    = t_idx + CW'(1) + CW'(left_free_r) + CW'(right_free);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    tb_nxt        = tb_r;
    stamp_nxt     = stamp_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    pick_base_nxt = pick_base_r;
    pick_len_nxt  = pick_len_r;
    key_nxt       = key_r;
    left_free_nxt = left_free_r;
    left_base_nxt = left_base_r;
    left_len_nxt  = left_len_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    res_nxt       = res_r;
    load_out      = 1'b0;
    out_nxt       = res_r;
    mem_ra        = AW'(idx_r + CW'(1));
    mem_we        = 1'b0;
    mem_wa        = pick_r;
    mem_wd        = entry_rd;

    unique case (state_r)
      S_IDLE: begin
        mem_ra = '0;
        if (accept) begin
          mode_nxt  = in_mode;
          size_nxt  = (req_raised == 16'd0) ? 16'd1 : req_raised;
          tb_nxt    = in_touch_base;
          stamp_nxt = in_stamp;
          idx_nxt   = '0;
          n_nxt     = '0;
          end_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (idx_r < count_r) begin
          idx_nxt = idx_r + CW'(1);
          case (mode_r)
            dpa_pkg::MODE_ALLOC: begin
              if (fits && better) begin
                found_nxt     = 1'b1;
                pick_nxt      = idx_r[AW-1:0];
                pick_base_nxt = entry_rd.base_addr;
                pick_len_nxt  = entry_rd.len;
                if (!fit_r) begin
                  state_nxt = S_AL_DEC;
                end
              end
            end
            dpa_pkg::MODE_EVICT: begin
              if (entry_rd.used && (!found_r || sel_stamp < key_r)) begin
                found_nxt     = 1'b1;
                pick_nxt      = idx_r[AW-1:0];
                pick_base_nxt = entry_rd.base_addr;
                pick_len_nxt  = entry_rd.len;
                key_nxt       = sel_stamp;
              end
            end
            dpa_pkg::MODE_COMPACT: begin
              if (entry_rd.used) begin
                if (!out_free) begin
                  // Hold here and re-read the same entry until the result side frees.
                  idx_nxt = idx_r;
                  mem_ra  = idx_r[AW-1:0];
                end else begin
                  load_out         = 1'b1;
                  out_nxt.status   = dpa_pkg::ST_MOVED;
                  out_nxt.base     = entry_rd.base_addr;
                  out_nxt.length   = entry_rd.len;
                  out_nxt.new_base = end_r[15:0];
                  out_nxt.slot     = 5'(n_r);
                  out_nxt.last     = (n_r + CW'(1) == CW'(MAX_PARTS));
                  mem_we           = 1'b1;
                  mem_wa           = n_r[AW-1:0];
                  mem_wd.base_addr = end_r[15:0];
                  end_nxt          = end_r + {1'b0, entry_rd.len};
                  n_nxt            = n_r + CW'(1);
                  if (n_r + CW'(1) == CW'(MAX_PARTS)) begin
                    count_nxt = CW'(MAX_PARTS);
                    state_nxt = S_IDLE;
                  end
                end
              end
            end
            default: begin
              if (entry_rd.used && entry_rd.base_addr == tb_r) begin
                mem_we           = 1'b1;
                mem_wa           = idx_r[AW-1:0];
                mem_wd.use_stamp = stamp_r;
                res_nxt          = '{status: dpa_pkg::ST_TOUCHED,
                                     base: entry_rd.base_addr, length: entry_rd.len,
                                     new_base: 16'd0, slot: 5'(idx_r), last: 1'b1};
                state_nxt        = S_EMIT;
              end
            end
          endcase
        end else begin
          case (mode_r)
            dpa_pkg::MODE_ALLOC:   state_nxt = S_AL_DEC;
            dpa_pkg::MODE_EVICT:   state_nxt = S_EV_DEC;
            dpa_pkg::MODE_COMPACT: state_nxt = S_CP_END;
            default: begin
              res_nxt   = '{status: dpa_pkg::ST_TOUCH_MISS, base: 16'd0, length: 16'd0,
                            new_base: 16'd0, slot: 5'd0, last: 1'b1};
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_AL_DEC: begin
        if (!found_r) begin
          res_nxt   = '{status: dpa_pkg::ST_NO_FIT, base: 16'd0, length: 16'd0,
                        new_base: 16'd0, slot: 5'd0, last: 1'b1};
          state_nxt = S_EMIT;
        end else if (pick_len_r > size_r && count_r < CW'(MAX_PARTS)) begin
          mem_ra    = AW'(count_r - CW'(1));
          idx_nxt   = count_r;
          state_nxt = S_SH_UP;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = pick_r;
          mem_wd    = '{base_addr: pick_base_r, len: pick_len_r, used: 1'b1,
                        alloc_stamp: stamp_r, use_stamp: stamp_r};
          res_nxt   = '{status: dpa_pkg::ST_ALLOCATED, base: pick_base_r,
                        length: pick_len_r, new_base: 16'd0, slot: 5'(pick_r), last: 1'b1};
          state_nxt = S_EMIT;
        end
      end

      // Open a hole behind the chosen partition, moving the table up one entry.
      S_SH_UP: begin
        mem_we = 1'b1;
        if (idx_r > CW'(pick_r) + CW'(1)) begin
          mem_wa  = idx_r[AW-1:0];
          mem_wd  = entry_rd;
          mem_ra  = AW'(idx_r - CW'(2));
          idx_nxt = idx_r - CW'(1);
        end else begin
          mem_wa    = AW'(CW'(pick_r) + CW'(1));
          mem_wd    = '{base_addr: pick_base_r + size_r, len: pick_len_r - size_r,
                        used: 1'b0, alloc_stamp: 32'd0, use_stamp: 32'd0};
          state_nxt = S_AL_WR;
        end
      end

      S_AL_WR: begin
        mem_we    = 1'b1;
        mem_wa    = pick_r;
        mem_wd    = '{base_addr: pick_base_r, len: size_r, used: 1'b1,
                      alloc_stamp: stamp_r, use_stamp: stamp_r};
        count_nxt = count_r + CW'(1);
        res_nxt   = '{status: dpa_pkg::ST_ALLOCATED, base: pick_base_r, length: size_r,
                      new_base: 16'd0, slot: 5'(pick_r), last: 1'b1};
        state_nxt = S_EMIT;
      end

      S_EV_DEC: begin
        if (!found_r) begin
          res_nxt   = '{status: dpa_pkg::ST_NO_VICTIM, base: 16'd0, length: 16'd0,
                        new_base: 16'd0, slot: 5'd0, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          res_nxt   = '{status: dpa_pkg::ST_EVICTED, base: pick_base_r, length: pick_len_r,
                        new_base: 16'd0, slot: 5'(pick_r), last: 1'b1};
          mem_ra    = pick_r - AW'(1);
          state_nxt = S_EV_L;
        end
      end

      S_EV_L: begin
        left_free_nxt = (pick_r != '0) && !entry_rd.used;
        left_base_nxt = entry_rd.base_addr;
        left_len_nxt  = entry_rd.len;
        mem_ra        = AW'(CW'(pick_r) + CW'(1));
        state_nxt     = S_EV_R;
      end

      // Write the freed, merged partition; close any gap left by the merge.
      S_EV_R: begin
        k_nxt  = {1'b0, left_free_r} + {1'b0, right_free};
        mem_we = 1'b1;
        mem_wa = t_idx[AW-1:0];
        mem_wd = '{base_addr: left_free_r ? left_base_r : pick_base_r,
                   len: (left_free_r ? left_len_r : 16'd0) + pick_len_r
                        + (right_free ? entry_rd.len : 16'd0),
                   used: 1'b0, alloc_stamp: 32'd0, use_stamp: 32'd0};
        if (k_nxt == 2'd0) begin
          state_nxt = S_EMIT;
        end else begin
          mem_ra    = src_idx[AW-1:0];
          idx_nxt   = src_idx;
          state_nxt = S_SH_DN;
        end
      end

      S_SH_DN: begin
        if (idx_r < count_r) begin
          mem_we  = 1'b1;
          mem_wa  = AW'(idx_r - CW'(k_r));
          mem_wd  = entry_rd;
          idx_nxt = idx_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(k_r);
          state_nxt = S_EMIT;
        end
      end

      S_CP_END: begin
        if (end_r < {1'b0, total_r}) begin
          mem_we    = 1'b1;
          mem_wa    = n_r[AW-1:0];
          mem_wd    = '{base_addr: end_r[15:0], len: total_r - end_r[15:0], used: 1'b0,
                        alloc_stamp: 32'd0, use_stamp: 32'd0};
          count_nxt = n_r + CW'(1);
          res_nxt   = '{status: dpa_pkg::ST_COMPACTED, base: end_r[15:0],
                        length: total_r - end_r[15:0], new_base: 16'd0,
                        slot: 5'(n_r), last: 1'b1};
        end else begin
          count_nxt = n_r;
          res_nxt   = '{status: dpa_pkg::ST_COMPACTED, base: end_r[15:0], length: 16'd0,
                        new_base: 16'd0, slot: 5'(n_r), last: 1'b1};
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    size_r      <= size_nxt;
    tb_r        <= tb_nxt;
    stamp_r     <= stamp_nxt;
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    pick_r      <= pick_nxt;
    found_r     <= found_nxt;
    pick_base_r <= pick_base_nxt;
    pick_len_r  <= pick_len_nxt;
    key_r       <= key_nxt;
    left_free_r <= left_free_nxt;
    left_base_r <= left_base_nxt;
    left_len_r  <= left_len_nxt;
    k_r         <= k_nxt;
    end_r       <= end_nxt;
    res_r       <= res_nxt;
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_base     = out_r.base;
  assign out_length   = out_r.length;
  assign out_new_base = out_r.new_base;
  assign out_slot     = out_r.slot;
  assign out_last     = out_r.last;

  `DPA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_PARTS), "partition count overflow")
  `DPA_ASSERT_NOW(a_idle_no_write, state_r == S_IDLE, !mem_we, "table written while idle")
  `DPA_ASSERT_NOW(a_load_free, load_out, out_free, "result overwrites a pending transfer")
  `DPA_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE, "accepted request not started")

endmodule

/* dv/dpa_checker.sv */
`timescale 1ns / 1ps
// Watcher for the partition allocator: tracks register writes, predicts the results of every
// request transfer and compares result transfers field by field. Depends on dpa_pkg.
module dpa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_touch_base,
  input  logic [31:0] in_stamp,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_base,
  input  logic [15:0] out_length,
  input  logic [15:0] out_new_base,
  input  logic [4:0]  out_slot,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output logic [15:0] recent_base
);

  localparam int NPARTS = dpa_pkg::MAX_PARTS_DEF;

  logic [15:0] total_size, min_size;
  logic        fit_best, victim_lru;

  logic [15:0] tbl_start[NPARTS];
  logic [15:0] tbl_len[NPARTS];
  logic        tbl_used[NPARTS];
  logic [31:0] tbl_astamp[NPARTS];
  logic [31:0] tbl_ustamp[NPARTS];
  int          tbl_count;

  dpa_pkg::result_t expected_results[$];

  function automatic void add_result(logic [2:0] st, logic [15:0] b, logic [15:0] l,
                                     logic [15:0] nb, int sl, logic lst);
    dpa_pkg::result_t r;
    r.status = st;
    r.base = b;
    r.length = l;
    r.new_base = nb;
    r.slot = sl[4:0];
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void move_entry(int dst, int src);
    tbl_start[dst] = tbl_start[src];
    tbl_len[dst] = tbl_len[src];
    tbl_used[dst] = tbl_used[src];
    tbl_astamp[dst] = tbl_astamp[src];
    tbl_ustamp[dst] = tbl_ustamp[src];
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < tbl_count; i++) move_entry(i, i + 1);
    tbl_count--;
  endfunction

  function automatic void add_free(int idx, logic [15:0] start, logic [15:0] len);
    for (int i = tbl_count; i > idx; i--) move_entry(i, i - 1);
    tbl_start[idx] = start;
    tbl_len[idx] = len;
    tbl_used[idx] = 1'b0;
    tbl_astamp[idx] = '0;
    tbl_ustamp[idx] = '0;
    tbl_count++;
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < NPARTS; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_used[i] = 1'b0;
      tbl_astamp[i] = '0;
      tbl_ustamp[i] = '0;
    end
    tbl_len[0] = dpa_pkg::TOTAL_SIZE_RST;
    tbl_count = 1;
  endfunction

  function automatic void allocate(logic [15:0] req, logic [31:0] stamp);
    logic [15:0] size;
    int pick;
    size = (req < min_size) ? min_size : req;
    pick = -1;
    if (size == 0) size = 16'd1;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_used[i] && tbl_len[i] >= size) begin
        if (!fit_best) begin
          pick = i;
          break;
        end
        if (pick < 0 || tbl_len[i] < tbl_len[pick]) pick = i;
      end
    end
    if (pick < 0) begin
      add_result(dpa_pkg::ST_NO_FIT, '0, '0, '0, 0, 1'b1);
      return;
    end
    if (tbl_len[pick] > size && tbl_count < NPARTS) begin
      add_free(pick + 1, tbl_start[pick] + size, tbl_len[pick] - size);
      tbl_len[pick] = size;
    end
    tbl_used[pick] = 1'b1;
    tbl_astamp[pick] = stamp;
    tbl_ustamp[pick] = stamp;
    add_result(dpa_pkg::ST_ALLOCATED, tbl_start[pick], tbl_len[pick], '0, pick, 1'b1);
  endfunction

  function automatic void evict();
    int v;
    v = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i]) begin
        if (v < 0) v = i;
        else if (victim_lru ? tbl_ustamp[i] < tbl_ustamp[v]
                            : tbl_astamp[i] < tbl_astamp[v]) v = i;
      end
    end
    if (v < 0) begin
      add_result(dpa_pkg::ST_NO_VICTIM, '0, '0, '0, 0, 1'b1);
      return;
    end
    add_result(dpa_pkg::ST_EVICTED, tbl_start[v], tbl_len[v], '0, v, 1'b1);
    tbl_used[v] = 1'b0;
    if (v > 0 && !tbl_used[v - 1]) begin
      tbl_len[v - 1] = tbl_len[v - 1] + tbl_len[v];
      drop_entry(v);
      v--;
    end
    if (v < tbl_count - 1 && !tbl_used[v + 1]) begin
      tbl_len[v] = tbl_len[v] + tbl_len[v + 1];
      drop_entry(v + 1);
    end
  endfunction

  function automatic void compact();
    int n;
    int unsigned pack_end;
    n = 0;
    pack_end = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i]) begin
        add_result(dpa_pkg::ST_MOVED, tbl_start[i], tbl_len[i], pack_end[15:0], n, 1'b0);
        move_entry(n, i);
        tbl_start[n] = pack_end[15:0];
        pack_end += tbl_len[n];
        n++;
      end
    end
    tbl_count = n;
    // With every slot used there is no room for a tail, so the last move closes the request.
    if (n >= NPARTS) begin
      expected_results[$].last = 1'b1;
    end else if (pack_end < total_size) begin
      add_free(n, pack_end[15:0], total_size - pack_end[15:0]);
      add_result(dpa_pkg::ST_COMPACTED, pack_end[15:0], total_size - pack_end[15:0], '0, n,
                 1'b1);
    end else begin
      add_result(dpa_pkg::ST_COMPACTED, pack_end[15:0], '0, '0, n, 1'b1);
    end
  endfunction

  function automatic void touch(logic [15:0] tb_base, logic [31:0] stamp);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i] && tbl_start[i] == tb_base) begin
        tbl_ustamp[i] = stamp;
        add_result(dpa_pkg::ST_TOUCHED, tbl_start[i], tbl_len[i], '0, i, 1'b1);
        return;
      end
    end
    add_result(dpa_pkg::ST_TOUCH_MISS, '0, '0, '0, 0, 1'b1);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    dpa_pkg::result_t exp_r;
    if (!rst_n) begin
      total_size = dpa_pkg::TOTAL_SIZE_RST;
      min_size = dpa_pkg::MIN_SIZE_RST;
      fit_best = 1'b0;
      victim_lru = 1'b0;
      reset_table();
      expected_results.delete();
      recent_base = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          dpa_pkg::REG_TOTAL_SIZE: total_size = pwdata[15:0];
          dpa_pkg::REG_MIN_SIZE:   min_size = pwdata[15:0];
          dpa_pkg::REG_FIT:        fit_best = pwdata[0];
          dpa_pkg::REG_VICTIM:     victim_lru = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual status %0d",
                   $time, out_status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", exp_r.status, out_status);
          check_field("base", exp_r.base, out_base);
          check_field("length", exp_r.length, out_length);
          check_field("new_base", exp_r.new_base, out_new_base);
          check_field("slot", exp_r.slot, out_slot);
          check_field("last", exp_r.last, out_last);
          if (out_status == dpa_pkg::ST_ALLOCATED) recent_base = out_base;
        end
      end
      if (in_valid && !in_stall) begin
        case (in_mode)
          dpa_pkg::MODE_ALLOC:   allocate(in_req_size, in_stamp);
          dpa_pkg::MODE_EVICT:   evict();
          dpa_pkg::MODE_COMPACT: compact();
          default:               touch(in_touch_base, in_stamp);
        endcase
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    recent_base = '0;
  end
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Top of the partition allocator testbench: clock, reset, register writes and request
// stimulus with random gaps and stalls. Depends on dpa_pkg, dpa_checker and the block.
module tb;

  localparam int LIMIT = 500000;
  localparam int NPHASES = 6;
  localparam int PHASE_ITEMS = 52;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = dpa_pkg::MODE_ALLOC;
  logic [15:0] in_req_size = '0, in_touch_base = '0;
  logic [31:0] in_stamp = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_base, out_length, out_new_base;
  logic [4:0]  out_slot;
  logic        out_last;
  int          errors, pending;
  logic [15:0] recent_base;
  int          cycles = 0;
  bit          steady = 1'b0;
  logic [31:0] stamp_now = 32'd1;

  dynamic_partition_allocator_unit u_dut (.*);

  dpa_checker u_chk (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver stalls at random except during the steady stretch.
  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 18);

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send(logic [1:0] mode, logic [15:0] req, logic [15:0] tbase,
                      logic [31:0] stamp);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_req_size <= req;
    in_touch_base <= tbase;
    in_stamp <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int req_max);
    int r;
    logic [1:0] mode;
    logic [15:0] req, tbase;
    r = $urandom_range(99);
    mode = (r < 50) ? dpa_pkg::MODE_ALLOC :
           (r < 70) ? dpa_pkg::MODE_EVICT :
           (r < 88) ? dpa_pkg::MODE_TOUCH : dpa_pkg::MODE_COMPACT;
    req = ($urandom_range(99) < 15) ? 16'($urandom) : 16'($urandom_range(req_max));
    tbase = ($urandom_range(99) < 70) ? recent_base : 16'($urandom);
    // Small increments, zero among them, give stamp ties; full-range stamps now and then.
    stamp_now = stamp_now + $urandom_range(3);
    send(mode, req, tbase, ($urandom_range(99) < 10) ? $urandom : stamp_now);
  endtask

  int          total_set[NPHASES] = '{4096, 65535, 64, 1, 300, 2048};
  int          min_set[NPHASES]   = '{16, 0, 1, 1, 65535, 4};
  int          fit_set[NPHASES]   = '{0, 1, 0, 1, 1, 0};
  int          lru_set[NPHASES]   = '{0, 1, 1, 0, 0, 1};
  int          req_max[NPHASES]   = '{200, 3000, 8, 2, 100, 64};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NPHASES; p++) begin
      wait_drained();
      write_reg(dpa_pkg::REG_TOTAL_SIZE, 16'(total_set[p]));
      write_reg(dpa_pkg::REG_MIN_SIZE, 16'(min_set[p]));
      write_reg(dpa_pkg::REG_FIT, 16'(fit_set[p]));
      write_reg(dpa_pkg::REG_VICTIM, 16'(lru_set[p]));
      steady = (p == 1);
      if (p == 0) begin
        send(dpa_pkg::MODE_EVICT, 16'd0, 16'd0, 32'd0);
        send(dpa_pkg::MODE_TOUCH, 16'd0, 16'd0, 32'd5);
        send(dpa_pkg::MODE_COMPACT, 16'd0, 16'd0, 32'd0);
        send(dpa_pkg::MODE_ALLOC, 16'd0, 16'hFFFF, 32'd10);
        send(dpa_pkg::MODE_ALLOC, 16'hFFFF, 16'd0, 32'd11);
        send(dpa_pkg::MODE_ALLOC, 16'd100, 16'd0, 32'd10);
        send(dpa_pkg::MODE_ALLOC, 16'd3980, 16'd0, 32'hFFFF_FFFF);
        send(dpa_pkg::MODE_TOUCH, 16'd0, 16'd16, 32'd3);
        send(dpa_pkg::MODE_TOUCH, 16'd0, 16'd5, 32'd3);
        send(dpa_pkg::MODE_EVICT, 16'd0, 16'd0, 32'd0);
        send(dpa_pkg::MODE_ALLOC, 16'd5, 16'd0, 32'd20);
        send(dpa_pkg::MODE_COMPACT, 16'd0, 16'd0, 32'd0);
        send(dpa_pkg::MODE_EVICT, 16'd0, 16'd0, 32'd0);
        send(dpa_pkg::MODE_EVICT, 16'd0, 16'd0, 32'd0);
        send(dpa_pkg::MODE_COMPACT, 16'd0, 16'd0, 32'd0);
      end
      if (p == 1) begin
        send(dpa_pkg::MODE_ALLOC, 16'd0, 16'd0, 32'd30);
        send(dpa_pkg::MODE_TOUCH, 16'hFFFF, 16'hFFFF, 32'd0);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random(req_max[p]);
        if (i == PHASE_ITEMS / 2 && p == 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      in_valid <= 1'b0;
    end
    steady = 1'b0;
    wait_drained();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
